// ===== rtl/lprd_pkg.sv =====
package lprd_pkg;

   // Request layout limits
   localparam int MAX_EXPERTS  = 8;
   localparam int HIDDEN_BYTES = 8192;
   localparam int REQ_HEAD     = 11;

   // Register reset values
   localparam logic [7:0]  REQUEST_TYPE_RESET = 8'd2;
   localparam logic [7:0]  BYE_TYPE_RESET     = 8'd4;
   localparam logic [15:0] PAYLOAD_CAP_RESET  = 16'd8268;

   typedef enum logic [1:0] {
      CSR_REQUEST_TYPE = 2'd0,
      CSR_BYE_TYPE     = 2'd1,
      CSR_PAYLOAD_CAP  = 2'd2
   } csr_index_type;

   // Parse phase, one-hot
   typedef enum logic [11:0] {
      PH_LEN     = 12'b0000_0000_0001,
      PH_TYPE    = 12'b0000_0000_0010,
      PH_LAYER   = 12'b0000_0000_0100,
      PH_SEQ     = 12'b0000_0000_1000,
      PH_COUNT   = 12'b0000_0001_0000,
      PH_ID      = 12'b0000_0010_0000,
      PH_WEIGHT  = 12'b0000_0100_0000,
      PH_HIDDEN  = 12'b0000_1000_0000,
      PH_ECOUNT  = 12'b0001_0000_0000,
      PH_EID     = 12'b0010_0000_0000,
      PH_OTHER   = 12'b0100_0000_0000,
      PH_DISCARD = 12'b1000_0000_0000
   } phase_type;

   typedef enum logic [3:0] {
      TAG_LEN     = 4'd0,
      TAG_TYPE    = 4'd1,
      TAG_LAYER   = 4'd2,
      TAG_SEQ     = 4'd3,
      TAG_COUNT   = 4'd4,
      TAG_ID      = 4'd5,
      TAG_WEIGHT  = 4'd6,
      TAG_HIDDEN  = 4'd7,
      TAG_ECOUNT  = 4'd8,
      TAG_EID     = 4'd9,
      TAG_OTHER   = 4'd10,
      TAG_DISCARD = 4'd11
   } tag_type;

   typedef enum logic [2:0] {
      V_MID       = 3'd0,
      V_REQ_OK    = 3'd1,
      V_OTHER     = 3'd2,
      V_BYE       = 3'd3,
      V_ZERO_LEN  = 3'd4,
      V_OVERSIZED = 3'd5,
      V_MALFORMED = 3'd6,
      V_CLOSED    = 3'd7
   } verdict_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [3:0]  field_tag;
      logic [12:0] field_byte_index;
      logic [7:0]  frame_kind;
      logic [31:0] payload_length;
      logic        frame_end;
      logic [2:0]  verdict;
   } rsp_type;

endpackage

// ===== rtl/lprd_req_if.sv =====
interface lprd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/lprd_rsp_if.sv =====
interface lprd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [3:0]  field_tag;
   logic [12:0] field_byte_index;
   logic [7:0]  frame_kind;
   logic [31:0] payload_length;
   logic        frame_end;
   logic [2:0]  verdict;

   modport source (output valid, output out_byte, output field_tag, output field_byte_index,
                   output frame_kind, output payload_length, output frame_end,
                   output verdict, input ready);
   modport sink   (input valid, input out_byte, input field_tag, input field_byte_index,
                   input frame_kind, input payload_length, input frame_end,
                   input verdict, output ready);
endinterface

// ===== rtl/lprd_skid.sv =====
module lprd_skid
   import lprd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    push, pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // drain the skid beat into the output
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_in = push;
         out_data_in  = in_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while output is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !out_ready))
      else $error("skid filled without an output stall");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid beat not moved to output");

endmodule

// ===== rtl/length_prefixed_request_deframer_unit.sv =====
// Channel   Direction  Payload                                        Beat taken when
// req_bus   in         data_byte                                      valid && ready
// rsp_bus   out        out_byte, field_tag, field_byte_index,         valid && ready
//                      frame_kind, payload_length, frame_end, verdict
// csr_*     in         csr_index, csr_wdata                           csr_we
//
// One byte a cycle while req is ready: each accepted beat yields exactly one result beat.
// The parse state and the result are updated together from one compare-and-count step.
// A two-entry output stage (output register plus skid) keeps req ready while one
// result waits; req drops only when both entries are full.
// Reset is synchronous; it restores the register defaults and reopens the stream.
module length_prefixed_request_deframer_unit
   import lprd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   lprd_req_if.sink     req_bus,
   lprd_rsp_if.source   rsp_bus,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   // Configuration
   logic [7:0]  req_code_ff;
   logic [7:0]  bye_code_ff;
   logic [15:0] cap_ff;

   // Parse state
   phase_type   phase_ff, phase_in;
   logic [13:0] fcount_ff, fcount_in;
   logic [31:0] length_ff, length_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  xcount_ff, xcount_in;
   logic [7:0]  ecount_ff, ecount_in;
   logic        bad_ff, bad_in;
   logic        closed_ff, closed_in;

   logic        accept;
   logic        stage_ready;
   logic [7:0]  b;
   rsp_type     res;
   rsp_type     rsp_data;

   // Scratch values of the step
   logic [1:0]  n;
   logic [31:0] lw_next;
   logic [31:0] pay;
   logic        is_req;
   logic        bad_new;
   logic [15:0] after;
   logic [13:0] fc1;
   logic [7:0]  xc_now;
   logic [7:0]  ec_now;
   logic [16:0] need_x;
   logic        bad_now;

   assign b      = req_bus.data_byte;
   assign accept = req_bus.valid && stage_ready;
   assign req_bus.ready = stage_ready;

   function automatic tag_type tag_of(phase_type ph);
      unique case (ph)
         PH_LEN:    return TAG_LEN;
         PH_TYPE:   return TAG_TYPE;
         PH_LAYER:  return TAG_LAYER;
         PH_SEQ:    return TAG_SEQ;
         PH_COUNT:  return TAG_COUNT;
         PH_ID:     return TAG_ID;
         PH_WEIGHT: return TAG_WEIGHT;
         PH_HIDDEN: return TAG_HIDDEN;
         PH_ECOUNT: return TAG_ECOUNT;
         PH_EID:    return TAG_EID;
         PH_OTHER:  return TAG_OTHER;
         default:   return TAG_DISCARD;
      endcase
   endfunction

   function automatic logic [13:0] field_len(phase_type ph, logic [7:0] xc, logic [7:0] ec);
      unique case (ph)
         PH_LAYER:  return 14'd2;
         PH_SEQ:    return 14'd8;
         PH_COUNT:  return 14'd1;
         PH_ID:     return {5'b0, xc, 1'b0};
         PH_WEIGHT: return {4'b0, xc, 2'b0};
         PH_HIDDEN: return 14'(HIDDEN_BYTES);
         PH_ECOUNT: return 14'd1;
         PH_EID:    return {5'b0, ec, 1'b0};
         default:   return 14'h3FFF;
      endcase
   endfunction

   // Skip fields that an empty count leaves out
   function automatic phase_type next_field(phase_type ph, logic [7:0] xc, logic [7:0] ec);
      unique case (ph)
         PH_LAYER:  return PH_SEQ;
         PH_SEQ:    return PH_COUNT;
         PH_COUNT:  return (xc != 8'd0) ? PH_ID : PH_HIDDEN;
         PH_ID:     return PH_WEIGHT;
         PH_WEIGHT: return PH_HIDDEN;
         PH_HIDDEN: return PH_ECOUNT;
         PH_ECOUNT: return (ec != 8'd0) ? PH_EID : PH_DISCARD;
         default:   return PH_DISCARD;
      endcase
   endfunction

   function automatic verdict_type end_verdict(logic [7:0] kind, logic [7:0] req_code,
                                               logic [7:0] bye_code, logic bad);
      if (kind == bye_code) begin
         return V_BYE;
      end else if (kind == req_code) begin
         return bad ? V_MALFORMED : V_REQ_OK;
      end
      return V_OTHER;
   endfunction

   always_comb begin
      phase_in  = phase_ff;
      fcount_in = fcount_ff;
      length_in = length_ff;
      left_in   = left_ff;
      kind_in   = kind_ff;
      xcount_in = xcount_ff;
      ecount_in = ecount_ff;
      bad_in    = bad_ff;
      closed_in = closed_ff;

      n       = fcount_ff[1:0];
      lw_next = length_ff | ({24'b0, b} << {n, 3'b000});
      pay     = length_ff - 32'd1;
      is_req  = (b != bye_code_ff) && (b == req_code_ff);
      bad_new = is_req && (pay < 32'(REQ_HEAD));
      after   = left_ff - 16'd1;
      fc1     = fcount_ff + 14'd1;
      xc_now  = (phase_ff == PH_COUNT) ? b : xcount_ff;
      ec_now  = (phase_ff == PH_ECOUNT) ? b : ecount_ff;
      need_x  = (17'(b) << 2) + (17'(b) << 1) + 17'(HIDDEN_BYTES) + 17'd1;
      bad_now = bad_ff;
      if (phase_ff == PH_COUNT) begin
         bad_now = bad_ff || (b > 8'(MAX_EXPERTS)) || ({1'b0, after} < need_x);
      end else if (phase_ff == PH_ECOUNT) begin
         bad_now = bad_ff || (b > 8'(MAX_EXPERTS)) || ({1'b0, after} < {8'b0, b, 1'b0});
      end

      res.out_byte         = b;
      res.field_tag        = TAG_DISCARD;
      res.field_byte_index = 13'd0;
      res.frame_kind       = 8'd0;
      res.payload_length   = 32'd0;
      res.frame_end        = 1'b0;
      res.verdict          = V_MID;

      if (closed_ff) begin
         // stream closed: pass the byte through as discard until reset
         res.verdict = V_CLOSED;
      end else if (phase_ff == PH_LEN) begin
         res.field_tag        = TAG_LEN;
         res.field_byte_index = {11'b0, n};
         length_in            = lw_next;
         fcount_in            = {12'b0, n} + 14'd1;
         if (n == 2'd3) begin
            fcount_in = 14'd0;
            if (lw_next == 32'd0) begin
               // zero length frame is fatal
               res.frame_end = 1'b1;
               res.verdict   = V_ZERO_LEN;
               closed_in     = 1'b1;
               length_in     = 32'd0;
            end else begin
               phase_in = PH_TYPE;
            end
         end
      end else if (phase_ff == PH_TYPE) begin
         res.field_tag      = TAG_TYPE;
         res.frame_kind     = b;
         res.payload_length = pay;
         kind_in            = b;
         fcount_in          = 14'd0;
         if (pay > {16'b0, cap_ff}) begin
            res.frame_end = 1'b1;
            res.verdict   = V_OVERSIZED;
            closed_in     = 1'b1;
            phase_in      = PH_LEN;
            length_in     = 32'd0;
            left_in       = 16'd0;
            kind_in       = 8'd0;
            bad_in        = 1'b0;
         end else begin
            left_in = pay[15:0];
            bad_in  = bad_new;
            if (pay == 32'd0) begin
               res.frame_end = 1'b1;
               res.verdict   = end_verdict(b, req_code_ff, bye_code_ff, bad_new);
               closed_in     = (b == bye_code_ff);
               phase_in      = PH_LEN;
               length_in     = 32'd0;
               left_in       = 16'd0;
               kind_in       = 8'd0;
               bad_in        = 1'b0;
            end else if (is_req) begin
               phase_in = bad_new ? PH_DISCARD : PH_LAYER;
            end else begin
               phase_in = PH_OTHER;
            end
         end
      end else begin
         res.field_tag        = tag_of(phase_ff);
         res.field_byte_index = fcount_ff[12:0];
         res.frame_kind       = kind_ff;
         res.payload_length   = pay;
         fcount_in            = fc1;
         if (phase_ff == PH_COUNT) begin
            xcount_in = b;
         end
         if (phase_ff == PH_ECOUNT) begin
            ecount_in = b;
         end
         if (phase_ff != PH_OTHER && phase_ff != PH_DISCARD) begin
            priority if (bad_now) begin
               // malformed: drop the rest of the payload
               phase_in  = PH_DISCARD;
               fcount_in = 14'd0;
            end else if (fc1 >= field_len(phase_ff, xc_now, ec_now)) begin
               phase_in  = next_field(phase_ff, xc_now, ec_now);
               fcount_in = 14'd0;
            end
         end
         bad_in  = bad_now;
         left_in = after;
         if (after == 16'd0) begin
            res.frame_end = 1'b1;
            res.verdict   = end_verdict(kind_ff, req_code_ff, bye_code_ff, bad_now);
            closed_in     = (kind_ff == bye_code_ff);
            phase_in      = PH_LEN;
            fcount_in     = 14'd0;
            length_in     = 32'd0;
            kind_in       = 8'd0;
            bad_in        = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_code_ff <= REQUEST_TYPE_RESET;
         bye_code_ff <= BYE_TYPE_RESET;
         cap_ff      <= PAYLOAD_CAP_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_REQUEST_TYPE: req_code_ff <= csr_wdata[7:0];
            CSR_BYE_TYPE:     bye_code_ff <= csr_wdata[7:0];
            CSR_PAYLOAD_CAP:  cap_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEN;
         fcount_ff <= 14'd0;
         length_ff <= 32'd0;
         left_ff   <= 16'd0;
         kind_ff   <= 8'd0;
         xcount_ff <= 8'd0;
         ecount_ff <= 8'd0;
         bad_ff    <= 1'b0;
         closed_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         fcount_ff <= fcount_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         kind_ff   <= kind_in;
         xcount_ff <= xcount_in;
         ecount_ff <= ecount_in;
         bad_ff    <= bad_in;
         closed_ff <= closed_in;
      end
   end

   // Output register and skid
   lprd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (stage_ready),
      .in_data   (res),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign rsp_bus.out_byte         = rsp_data.out_byte;
   assign rsp_bus.field_tag        = rsp_data.field_tag;
   assign rsp_bus.field_byte_index = rsp_data.field_byte_index;
   assign rsp_bus.frame_kind       = rsp_data.frame_kind;
   assign rsp_bus.payload_length   = rsp_data.payload_length;
   assign rsp_bus.frame_end        = rsp_data.frame_end;
   assign rsp_bus.verdict          = rsp_data.verdict;

   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("closed stream reopened without reset");

   a_bad_discards: assert property (@(posedge clock) disable iff (reset)
      bad_ff |-> (phase_ff == PH_DISCARD))
      else $error("malformed request not in discard phase");

   a_length_known: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_LEN) |-> (length_ff != 32'd0))
      else $error("frame body entered with zero length");

endmodule
